### sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fcfs_sm_pkg.sv
package fcfs_sm_pkg;

  // Capacity of the job store.
  localparam int MAX_JOBS = 16;

  // Index into the store and a count that can also hold MAX_JOBS itself.
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // Fixed field widths.
  localparam int TIME_W    = 16;
  localparam int WIDE_W    = 24;
  localparam int JOB_NUM_W = 6;
  localparam int JOB_OUT_W = 7;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;

  // One stored job: arrival, burst and load position minus one.
  typedef struct packed {
    logic [TIME_W-1:0]    arrival;
    logic [TIME_W-1:0]    burst;
    logic [JOB_NUM_W-1:0] number;
  } job_entry_t;

  localparam int ENTRY_W = $bits(job_entry_t);

  // Request and response of the shared add/subtract unit.
  typedef struct packed {
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [WIDE_W-1:0] result;
    logic              borrow;
  } alu_rsp_t;

endpackage

### sv/fcfs_sm_ram.sv
module fcfs_sm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/fcfs_sm_alu.sv
module fcfs_sm_alu
  import fcfs_sm_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [WIDE_W:0] sum;

  // Add or subtract; the top bit is the borrow when subtracting.
  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.result = sum[WIDE_W-1:0];
    rsp.borrow = req.sub & sum[WIDE_W];
  end

endmodule

### sv/fcfs_schedule_metrics.sv
// First-come-first-served schedule metrics.
// Input channel s_*: one job per item, tdata holds arrival and burst, tlast
// marks the final job of a batch. Each job is placed into a store kept sorted
// by arrival time (ties keep load order); jobs beyond MAX_JOBS are dropped,
// but a dropped item marked last still starts scheduling.
// Output channel m_*: one item per stored job in execution order, tlast on
// the final one of the batch.
// Loading a job compares it with each stored job from the top down and moves
// every stored job with a later arrival up one slot before the new job is
// written; the compare loop runs through the single read port of the job
// store. Scheduling a job takes a store read and five passes through the one
// shared 24-bit add/subtract unit.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register; if the receiver stalls, the next job is worked out
// and held until that register frees up.
// Reset clears the sequencer, the job count and the output valid; the store
// contents are not cleared. After each batch the job count returns to zero.
module fcfs_schedule_metrics
  import fcfs_sm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: arrival_time[15:0], burst_length[31:16]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: job_number[6:0], job_arrival[22:7], job_burst[38:23],
  // completion_time[62:39], turnaround_time[86:63], waiting_time[110:87],
  // response_time[134:111], zero pad[135]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CMP   = 4'd1;
  localparam logic [3:0] ST_WRITE = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_START = 4'd4;
  localparam logic [3:0] ST_DONE  = 4'd5;
  localparam logic [3:0] ST_TAT   = 4'd6;
  localparam logic [3:0] ST_WAIT  = 4'd7;
  localparam logic [3:0] ST_RESP  = 4'd8;

  logic [3:0]        state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  k;
  logic [TIME_W-1:0] arr_reg;
  logic [TIME_W-1:0] bur_reg;
  logic              last_reg;
  logic [WIDE_W-1:0] clock_time;
  logic [WIDE_W-1:0] start_r;
  logic [WIDE_W-1:0] done_r;
  logic [WIDE_W-1:0] tat_r;
  logic [WIDE_W-1:0] wait_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  job_entry_t        wr_data;
  logic [IDX_W-1:0]  rd_addr;
  job_entry_t        rd_q;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic [CNT_W-1:0]  count_m1;
  logic [IDX_W-1:0]  pos_m2;
  logic              s_fire;
  logic              out_free;
  logic              is_final;
  logic [JOB_OUT_W-1:0] num_out;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign count_m1 = count - CNT_W'(1);
  assign pos_m2   = pos - IDX_W'(2);
  assign is_final = (CNT_W'(k) + CNT_W'(1)) == count;
  assign num_out  = JOB_OUT_W'(rd_q.number) + JOB_OUT_W'(1);

  fcfs_sm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  fcfs_sm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Store read address: the entry below the insert point while loading,
  // the current job while scheduling.
  always_comb begin
    case (state)
      ST_IDLE: rd_addr = count_m1[IDX_W-1:0];
      ST_CMP:  rd_addr = pos_m2;
      default: rd_addr = k;
    endcase
  end

  // Store writes: move a later job up, or place the new job.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = rd_q;
    if (state == ST_CMP && alu_rsp.borrow) begin
      wr_en = 1'b1;
    end else if (state == ST_WRITE) begin
      wr_en   = 1'b1;
      wr_data = '{arrival: arr_reg, burst: bur_reg, number: JOB_NUM_W'(count)};
    end
  end

  // Operand selection for the shared add/subtract unit.
  always_comb begin
    alu_req = '0;
    case (state)
      ST_CMP: begin
        alu_req = '{a: WIDE_W'(arr_reg), b: WIDE_W'(rd_q.arrival), sub: 1'b1};
      end
      ST_START: begin
        alu_req = '{a: clock_time, b: WIDE_W'(rd_q.arrival), sub: 1'b1};
      end
      ST_DONE: begin
        alu_req = '{a: start_r, b: WIDE_W'(rd_q.burst), sub: 1'b0};
      end
      ST_TAT: begin
        alu_req = '{a: done_r, b: WIDE_W'(rd_q.arrival), sub: 1'b1};
      end
      ST_WAIT: begin
        alu_req = '{a: tat_r, b: WIDE_W'(rd_q.burst), sub: 1'b1};
      end
      ST_RESP: begin
        alu_req = '{a: start_r, b: WIDE_W'(rd_q.arrival), sub: 1'b1};
      end
      default: alu_req = '0;
    endcase
  end

  // Sequencer for loading and scheduling.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      clock_time <= '0;
      k          <= '0;
      pos        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            arr_reg  <= s_tdata[TIME_W-1:0];
            bur_reg  <= s_tdata[2*TIME_W-1:TIME_W];
            last_reg <= s_tlast;
            pos      <= IDX_W'(count);
            if (count < CNT_W'(MAX_JOBS)) begin
              state <= (count == '0) ? ST_WRITE : ST_CMP;
            end else if (s_tlast) begin
              k          <= '0;
              clock_time <= '0;
              state      <= ST_RD;
            end
          end
        end
        ST_CMP: begin
          // A stored job arriving later than the new one moves up one slot.
          if (alu_rsp.borrow) begin
            pos <= pos - IDX_W'(1);
            if (pos == IDX_W'(1)) begin
              state <= ST_WRITE;
            end
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          count <= count + CNT_W'(1);
          if (last_reg) begin
            k          <= '0;
            clock_time <= '0;
            state      <= ST_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_START;
        end
        ST_START: begin
          // An idle processor jumps forward to the arrival.
          start_r <= alu_rsp.borrow ? WIDE_W'(rd_q.arrival) : clock_time;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          done_r <= alu_rsp.result;
          state  <= ST_TAT;
        end
        ST_TAT: begin
          tat_r <= alu_rsp.result;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          wait_r <= alu_rsp.result;
          state  <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            clock_time <= done_r;
            k          <= k + IDX_W'(1);
            if (is_final) begin
              count      <= '0;
              clock_time <= '0;
              state      <= ST_IDLE;
            end else begin
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_tdata <= {1'b0, alu_rsp.result, wait_r, tat_r, done_r,
                  rd_q.burst, rd_q.arrival, num_out};
      m_tlast <= is_final;
    end
  end

endmodule

### sv/fcfs_sm_checker.sv
`include "assert_macros.svh"

module fcfs_sm_checker
  import fcfs_sm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  logic [WIDE_W-1:0] arr_w;
  logic [WIDE_W-1:0] bur_w;
  logic [WIDE_W-1:0] comp_w;
  logic [WIDE_W-1:0] tat_w;
  logic [WIDE_W-1:0] wait_w;
  logic [WIDE_W-1:0] resp_w;
  logic [WIDE_W-1:0] tat_calc;
  logic [WIDE_W-1:0] wait_calc;
  logic              in_last_fire;

  assign arr_w     = WIDE_W'(m_tdata[22:7]);
  assign bur_w     = WIDE_W'(m_tdata[38:23]);
  assign comp_w    = m_tdata[62:39];
  assign tat_w     = m_tdata[86:63];
  assign wait_w    = m_tdata[110:87];
  assign resp_w    = m_tdata[134:111];
  assign tat_calc  = comp_w - arr_w;
  assign wait_calc = tat_w - bur_w;
  assign in_last_fire = s_tvalid && s_tready && s_tlast && (s_tdata == s_tdata);

  // A stalled result holds its payload.
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  // Job numbers stay within the store capacity.
  `ASSERT_IMPL(a_job_num, m_tvalid, (m_tdata[6:0] != 7'd0) && (m_tdata[6:0] <= 7'(MAX_JOBS)), "job number out of range")

  // Turnaround and waiting follow from completion, arrival and burst.
  `ASSERT_IMPL(a_metrics, m_tvalid, (tat_w == tat_calc) && (wait_w == wait_calc), "inconsistent turnaround or waiting time")

  // Without preemption the response time equals the waiting time.
  `ASSERT_IMPL(a_resp_wait, m_tvalid, resp_w == wait_w, "response differs from waiting time")

  // The block is busy right after taking the final job of a batch.
  `ASSERT_NEXT(a_busy_after_last, in_last_fire, !s_tready, "ready right after final job")

endmodule

bind fcfs_schedule_metrics fcfs_sm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
